### rtl/sfla_pkg.sv
// Package for the slab free-list allocator: sizes, status codes, link type and per-class functions.
package sfla_pkg;

    localparam int PAGE_BYTES   = 4096;
    localparam int CLASS_COUNT  = 9;
    localparam int HEADER_BYTES = 8;

    localparam int MIN_SHIFT  = 3;
    localparam int MIN_ENTRY  = 1 << MIN_SHIFT;
    localparam int SLOT_CAP   = PAGE_BYTES / MIN_ENTRY;
    localparam int SLOT_W     = $clog2(SLOT_CAP);
    localparam int LINK_DEPTH = CLASS_COUNT * SLOT_CAP;
    localparam int ADDR_W     = $clog2(LINK_DEPTH);
    localparam int CIDX_W     = ADDR_W - SLOT_W;

    // Field widths of the stream items.
    localparam int CLS_W   = 4;
    localparam int OFF_W   = 12;
    localparam int GSLOT_W = 9;
    localparam int ST_W    = 2;
    localparam int SPAN_W  = 17;
    localparam int SH_W    = 5;

    typedef enum logic [ST_W-1:0] {
        ST_DONE    = 2'd0,
        ST_EMPTY   = 2'd1,
        ST_IGNORED = 2'd2
    } t_status;

    // One next-link entry: the following slot and whether there is one.
    typedef struct packed {
        logic              valid;
        logic [SLOT_W-1:0] slot;
    } t_link;

    // Byte offset of slot 0: the header rounded up to a whole entry.
    function automatic int hdr_span(input logic [CLS_W-1:0] c);
        int e_shift;
        int e;
        e_shift = MIN_SHIFT + int'(c);
        e       = 1 << e_shift;
        return ((HEADER_BYTES + e - 1) >> e_shift) << e_shift;
    endfunction

    // Number of slots that fit in the page after the header.
    function automatic int slot_count(input logic [CLS_W-1:0] c);
        int span;
        int n;
        span = hdr_span(c);
        if (span >= PAGE_BYTES) begin
            n = 0;
        end else begin
            n = (PAGE_BYTES - span) >> (MIN_SHIFT + int'(c));
        end
        if (n > SLOT_CAP) begin
            n = SLOT_CAP;
        end
        return n;
    endfunction

endpackage

### rtl/slab_free_list_allocator.sv
// Slab free-list allocator: per-class LIFO free lists with heads in flops and links in RAM.
//
// A free or a failed allocate leaves the block idle; a successful allocate passes
// through a pop state, because the new head is the popped slot's link and the
// link memory read is registered. After reset the link memory is initialized by
// a clearing pass (one entry per cycle, all classes in turn), during which no
// item is accepted. Each item gives one result in a single result register, so
// the next item is taken only when that register is empty or its result leaves
// in the same cycle.
module slab_free_list_allocator (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [15:0] i_s_tdata,  // size_class[3:0], entry_offset[15:4]
    input  logic        i_s_tuser,  // mode[0]: 0 allocate, 1 free
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [23:0] o_m_tdata,  // given_offset[11:0], given_slot[20:12], zero[23:21]
    output logic [1:0]  o_m_tuser   // status[1:0]
);
    import sfla_pkg::*;

    typedef enum logic [2:0] {
        S_CLEAR = 3'b001,
        S_IDLE  = 3'b010,
        S_POP   = 3'b100
    } t_state;

    t_state r_state, n_state;

    logic [SLOT_W-1:0] r_head     [CLASS_COUNT];
    logic              r_head_vld [CLASS_COUNT];
    logic [CIDX_W-1:0] r_pop_cls;
    logic [ADDR_W-1:0] r_clr_idx;

    t_link             r_link_mem [LINK_DEPTH];
    t_link             r_link_rd;

    logic              r_out_valid;
    logic [OFF_W-1:0]  r_out_off;
    logic [GSLOT_W-1:0] r_out_slot;
    t_status           r_out_status;

    // Input fields and accept.
    logic              in_mode;
    logic [CLS_W-1:0]  in_cls;
    logic [OFF_W-1:0]  in_off;
    logic              accept;
    logic              known;
    logic [CIDX_W-1:0] cidx;
    logic [SLOT_W-1:0] hd;
    logic              hv;
    logic [SPAN_W-1:0] span;
    logic [SLOT_W:0]   n_slots;
    logic [SH_W-1:0]   shift;
    logic [SPAN_W-1:0] off_ext;
    logic [SPAN_W-1:0] s_full;
    logic              alloc_ok;
    logic              free_ok;

    // Result of the item being accepted.
    logic [OFF_W-1:0]  res_off;
    logic [GSLOT_W-1:0] res_slot;
    t_status           res_status;

    // Clearing pass.
    logic [CIDX_W-1:0] clr_c;
    logic [SLOT_W-1:0] clr_s;
    logic [SLOT_W:0]   clr_next;
    logic [SLOT_W:0]   clr_n;

    // Memory ports.
    logic              mem_we;
    logic [ADDR_W-1:0] mem_waddr;
    t_link             mem_wdata;
    logic [ADDR_W-1:0] mem_raddr;

    assign in_mode = i_s_tuser;
    assign in_cls  = i_s_tdata[3:0];
    assign in_off  = i_s_tdata[15:4];

    assign o_s_tready = (r_state == S_IDLE) && (!r_out_valid || i_m_tready);
    assign accept     = i_s_tvalid && o_s_tready;

    always_comb begin
        known    = (int'(in_cls) < CLASS_COUNT);
        cidx     = known ? in_cls[CIDX_W-1:0] : '0;
        hd       = r_head[cidx];
        hv       = r_head_vld[cidx] && known;
        span     = SPAN_W'(hdr_span(in_cls));
        n_slots  = (SLOT_W + 1)'(slot_count(in_cls));
        shift    = SH_W'(MIN_SHIFT) + SH_W'(in_cls);
        off_ext  = SPAN_W'(in_off);
        s_full   = (off_ext - span) >> shift;
        alloc_ok = !in_mode && hv;
        free_ok  = in_mode && known && (in_off != '0) && (off_ext >= span)
                   && (s_full < SPAN_W'(n_slots));

        res_off    = '0;
        res_slot   = '0;
        res_status = ST_IGNORED;
        if (!in_mode) begin
            if (hv) begin
                res_off    = OFF_W'(span + (SPAN_W'(hd) << shift));
                res_slot   = GSLOT_W'(hd);
                res_status = ST_DONE;
            end else begin
                res_status = ST_EMPTY;
            end
        end else if (free_ok) begin
            res_status = ST_DONE;
        end
    end

    // Initial chain for the entry under the clearing counter.
    always_comb begin
        clr_c    = r_clr_idx[ADDR_W-1:SLOT_W];
        clr_s    = r_clr_idx[SLOT_W-1:0];
        clr_next = (SLOT_W + 1)'(clr_s) + 1'b1;
        clr_n    = (SLOT_W + 1)'(slot_count(CLS_W'(clr_c)));
    end

    always_comb begin
        mem_raddr = {cidx, hd};
        if (r_state == S_CLEAR) begin
            mem_we          = 1'b1;
            mem_waddr       = r_clr_idx;
            mem_wdata.valid = (clr_next < clr_n);
            mem_wdata.slot  = clr_next[SLOT_W-1:0];
        end else begin
            // A free pushes its slot: the old head becomes its link.
            mem_we          = accept && free_ok;
            mem_waddr       = {cidx, s_full[SLOT_W-1:0]};
            mem_wdata.valid = hv;
            mem_wdata.slot  = hd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_link_mem[mem_waddr] <= mem_wdata;
        end
        r_link_rd <= r_link_mem[mem_raddr];
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_CLEAR: begin
                if (int'(r_clr_idx) == LINK_DEPTH - 1) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (accept && alloc_ok) begin
                    n_state = S_POP;
                end
            end
            S_POP: begin
                n_state = S_IDLE;
            end
            default: begin
                n_state = S_CLEAR;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_clr_idx   <= '0;
            r_out_valid <= 1'b0;
            for (int k = 0; k < CLASS_COUNT; k++) begin
                r_head[k]     <= '0;
                r_head_vld[k] <= (slot_count(CLS_W'(k)) != 0);
            end
        end else begin
            r_state <= n_state;
            if (r_state == S_CLEAR) begin
                r_clr_idx <= r_clr_idx + 1'b1;
            end
            if (accept) begin
                r_out_valid <= 1'b1;
            end else if (i_m_tready) begin
                r_out_valid <= 1'b0;
            end
            if (accept && free_ok) begin
                r_head[cidx]     <= s_full[SLOT_W-1:0];
                r_head_vld[cidx] <= 1'b1;
            end
            if (r_state == S_POP) begin
                r_head[r_pop_cls]     <= r_link_rd.slot;
                r_head_vld[r_pop_cls] <= r_link_rd.valid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_out_off    <= res_off;
            r_out_slot   <= res_slot;
            r_out_status <= res_status;
            r_pop_cls    <= cidx;
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = {3'b000, r_out_slot, r_out_off};
    assign o_m_tuser  = r_out_status;

`ifndef ASSERT_OFF
    // A successful pop must hold off the next item until the new head is loaded.
    a_pop_interlock: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && alloc_ok) |=> (r_state == S_POP) && !o_s_tready)
        else $error("item accepted while a pop was still pending");

    // An accepted item always leaves a result in the output register.
    a_result_loaded: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |=> r_out_valid)
        else $error("accepted item produced no result");

    // Only a successful allocate reports a nonzero offset or slot.
    a_zero_unless_alloc: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && (r_out_status != ST_DONE)) |-> (r_out_off == '0) && (r_out_slot == '0))
        else $error("failed or ignored item reported an offset");
`endif

endmodule

### tb/sv/slab_free_list_allocator_tb.sv
// Testbench for the slab free-list allocator: directed table, then random allocate/free traffic.
`timescale 1ns / 1ps

module slab_free_list_allocator_tb;
    import sfla_pkg::*;

    localparam logic MODE_ALLOC = 1'b0;
    localparam logic MODE_FREE  = 1'b1;
    localparam int   WATCHDOG_LIMIT = 20000;
    localparam int   HOLD_CYCLES    = 400;
    localparam int   DRAIN_CYCLES   = 20;
    localparam int   PRINT_LIMIT    = 100;

    typedef struct packed {
        logic [OFF_W-1:0]   off;
        logic [GSLOT_W-1:0] slot;
        t_status            st;
    } t_grant;

    typedef struct {
        logic             md;
        logic [CLS_W-1:0] cls;
        logic [OFF_W-1:0] off;
        bit               typed;
        t_grant           res;
    } t_row;

    typedef struct {
        logic [CLS_W-1:0] cls;
        logic [OFF_W-1:0] off;
    } t_live;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_s_tvalid = 1'b0;
    logic        o_s_tready;
    logic [15:0] i_s_tdata = '0;  // size_class[3:0], entry_offset[15:4]
    logic        i_s_tuser = 1'b0;  // mode[0]
    logic        o_m_tvalid;
    logic        i_m_tready = 1'b0;
    logic [23:0] o_m_tdata;  // given_offset[11:0], given_slot[20:12], zero[23:21]
    logic [1:0]  o_m_tuser;  // status[1:0]

    // Mirror of the allocator state.
    logic [SLOT_W-1:0] head_slot [CLASS_COUNT];
    logic              head_ok   [CLASS_COUNT];
    t_link             link_mem  [CLASS_COUNT][SLOT_CAP];

    t_grant grant_q [$];
    t_live  live_q [$];
    t_row   plan [$];

    int s_idle = 0;
    int m_idle = 0;
    int hold_req = 0;
    int hold_left = 0;
    int err_count = 0;
    int quiet_cycles = 0;

    slab_free_list_allocator u_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .i_s_tuser  (i_s_tuser),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata),
        .o_m_tuser  (o_m_tuser)
    );

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    function automatic int ent_bytes(input logic [CLS_W-1:0] c);
        return MIN_ENTRY << c;
    endfunction

    // The header is rounded up to a whole entry, so slot 0 starts there.
    function automatic int first_slot_at(input logic [CLS_W-1:0] c);
        int e;
        e = ent_bytes(c);
        return ((HEADER_BYTES + e - 1) / e) * e;
    endfunction

    function automatic int slots_in(input logic [CLS_W-1:0] c);
        int h;
        int n;
        h = first_slot_at(c);
        if (h >= PAGE_BYTES) begin
            return 0;
        end
        n = (PAGE_BYTES - h) / ent_bytes(c);
        return (n > SLOT_CAP) ? SLOT_CAP : n;
    endfunction

    function automatic void clear_lists();
        int n;
        for (int c = 0; c < CLASS_COUNT; c++) begin
            n = slots_in(CLS_W'(c));
            head_slot[c] = '0;
            head_ok[c]   = (n > 0);
            for (int i = 0; i < SLOT_CAP; i++) begin
                link_mem[c][i].valid = (i + 1 < n);
                link_mem[c][i].slot  = (i + 1 < n) ? SLOT_W'(i + 1) : '0;
            end
        end
    endfunction

    // Applies one request to the mirrored lists and returns its grant.
    function automatic t_grant grant_for(input logic md, input logic [CLS_W-1:0] cls,
                                         input logic [OFF_W-1:0] off);
        t_grant g;
        t_live  lv;
        logic [SLOT_W-1:0] h;
        int s;
        bit known;
        g = '0;
        known = (int'(cls) < CLASS_COUNT);
        if (md == MODE_ALLOC) begin
            if (!known || !head_ok[cls]) begin
                g.st = ST_EMPTY;
            end else begin
                h = head_slot[cls];
                g.slot = h;
                g.off  = OFF_W'(first_slot_at(cls) + int'(h) * ent_bytes(cls));
                g.st   = ST_DONE;
                head_slot[cls] = link_mem[cls][h].slot;
                head_ok[cls]   = link_mem[cls][h].valid;
                lv.cls = cls;
                lv.off = g.off;
                live_q.push_back(lv);
            end
        end else begin
            g.st = ST_IGNORED;
            if (known && off != 0 && int'(off) >= first_slot_at(cls)) begin
                s = (int'(off) - first_slot_at(cls)) / ent_bytes(cls);
                if (s < slots_in(cls)) begin
                    link_mem[cls][s].slot  = head_slot[cls];
                    link_mem[cls][s].valid = head_ok[cls];
                    head_slot[cls] = SLOT_W'(s);
                    head_ok[cls]   = 1'b1;
                    g.st = ST_DONE;
                end
            end
        end
        return g;
    endfunction

    task automatic add_row(input logic md, input logic [CLS_W-1:0] cls,
                           input logic [OFF_W-1:0] off, input bit typed,
                           input logic [OFF_W-1:0] g_off, input logic [GSLOT_W-1:0] g_slot,
                           input t_status st);
        t_row r;
        r.md = md;
        r.cls = cls;
        r.off = off;
        r.typed = typed;
        r.res.off = g_off;
        r.res.slot = g_slot;
        r.res.st = st;
        plan.push_back(r);
    endtask

    // Called at a falling edge; returns at the falling edge after the item is taken.
    task automatic offer(input logic md, input logic [CLS_W-1:0] cls,
                         input logic [OFF_W-1:0] off, input bit typed, input t_grant fixed);
        t_grant want;
        while ($urandom_range(0, 99) < s_idle) begin
            i_s_tvalid <= 1'b0;
            @(negedge i_clk);
        end
        i_s_tvalid <= 1'b1;
        i_s_tuser  <= md;
        i_s_tdata  <= {off, cls};
        @(posedge i_clk);
        while (!o_s_tready) begin
            @(posedge i_clk);
        end
        want = grant_for(md, cls, off);
        if (typed) begin
            want = fixed;
        end
        grant_q.push_back(want);
        @(negedge i_clk);
    endtask

    function automatic logic [CLS_W-1:0] pick_class();
        int r;
        r = $urandom_range(0, 99);
        if (r < 70) begin
            return CLS_W'($urandom_range(5, 8));
        end else if (r < 90) begin
            return CLS_W'($urandom_range(0, 4));
        end
        return CLS_W'($urandom_range(9, 15));
    endfunction

    // Mostly allocates and frees of entries handed out earlier, with some noise.
    task automatic run_random(input int count);
        int r;
        int idx;
        t_live lv;
        logic [OFF_W-1:0] off;
        for (int k = 0; k < count; k++) begin
            r = $urandom_range(0, 99);
            if (r < 40 || (r < 80 && live_q.size() == 0)) begin
                offer(MODE_ALLOC, pick_class(), OFF_W'($urandom_range(0, 4095)), 1'b0, '0);
            end else if (r < 80) begin
                idx = $urandom_range(0, live_q.size() - 1);
                lv = live_q[idx];
                live_q.delete(idx);
                off = lv.off;
                // A pointer into the middle of the entry still frees that entry.
                if ($urandom_range(0, 3) == 0) begin
                    off = OFF_W'(int'(lv.off) + $urandom_range(0, ent_bytes(lv.cls) - 1));
                end
                offer(MODE_FREE, lv.cls, off, 1'b0, '0);
            end else begin
                offer(1'($urandom_range(0, 1)), CLS_W'($urandom_range(0, 15)),
                      OFF_W'($urandom_range(0, 4095)), 1'b0, '0);
            end
        end
    endtask

    task automatic report(input string field, input int want, input int got);
        err_count++;
        if (err_count <= PRINT_LIMIT) begin
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, field, want, got);
        end
    endtask

    always @(negedge i_clk) begin
        if (hold_req != 0) begin
            hold_left = HOLD_CYCLES;
            hold_req  = 0;
        end
        if (hold_left > 0) begin
            hold_left = hold_left - 1;
            i_m_tready <= 1'b0;
        end else begin
            i_m_tready <= ($urandom_range(0, 99) >= m_idle);
        end
    end

    always @(posedge i_clk) begin
        t_grant want;
        if (i_rst_n && o_m_tvalid && i_m_tready) begin
            if (grant_q.size() == 0) begin
                err_count++;
                if (err_count <= PRINT_LIMIT) begin
                    $display("%0t: item with nothing expected, offset %0d slot %0d status %0d",
                             $time, o_m_tdata[11:0], o_m_tdata[20:12], o_m_tuser);
                end
            end else begin
                want = grant_q.pop_front();
                if (o_m_tdata[11:0] !== want.off) begin
                    report("given_offset", int'(want.off), int'(o_m_tdata[11:0]));
                end
                if (o_m_tdata[20:12] !== want.slot) begin
                    report("given_slot", int'(want.slot), int'(o_m_tdata[20:12]));
                end
                if (o_m_tuser !== want.st) begin
                    report("status", int'(want.st), int'(o_m_tuser));
                end
            end
        end
    end

    // Reset is followed by a long clearing pass, so the limit is generous.
    always @(posedge i_clk) begin
        if ((i_s_tvalid && o_s_tready) || (o_m_tvalid && i_m_tready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles + 1 >= WATCHDOG_LIMIT) begin
            $display("%0t: watchdog, no item moved for %0d cycles", $time, WATCHDOG_LIMIT);
            $display("simulation failed");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial begin
        clear_lists();

        add_row(MODE_ALLOC, 4'd0,  12'd0,    1'b1, 12'd8,    9'd0, ST_DONE);
        add_row(MODE_ALLOC, 4'd8,  12'd0,    1'b1, 12'd2048, 9'd0, ST_DONE);
        add_row(MODE_ALLOC, 4'd8,  12'd0,    1'b1, 12'd0,    9'd0, ST_EMPTY);
        add_row(MODE_ALLOC, 4'd9,  12'd4095, 1'b1, 12'd0,    9'd0, ST_EMPTY);
        add_row(MODE_ALLOC, 4'd15, 12'd0,    1'b1, 12'd0,    9'd0, ST_EMPTY);
        add_row(MODE_FREE,  4'd15, 12'd2048, 1'b1, 12'd0,    9'd0, ST_IGNORED);
        add_row(MODE_FREE,  4'd0,  12'd0,    1'b1, 12'd0,    9'd0, ST_IGNORED);
        add_row(MODE_FREE,  4'd8,  12'd2047, 1'b1, 12'd0,    9'd0, ST_IGNORED);
        add_row(MODE_FREE,  4'd8,  12'd4095, 1'b1, 12'd0,    9'd0, ST_DONE);
        add_row(MODE_ALLOC, 4'd8,  12'd0,    1'b1, 12'd2048, 9'd0, ST_DONE);
        add_row(MODE_FREE,  4'd0,  12'd4095, 1'b0, '0, '0, ST_DONE);
        add_row(MODE_ALLOC, 4'd0,  12'd0,    1'b0, '0, '0, ST_DONE);
        add_row(MODE_FREE,  4'd0,  12'd8,    1'b0, '0, '0, ST_DONE);
        add_row(MODE_FREE,  4'd0,  12'd8,    1'b0, '0, '0, ST_DONE);
        add_row(MODE_ALLOC, 4'd0,  12'd0,    1'b0, '0, '0, ST_DONE);
        add_row(MODE_ALLOC, 4'd0,  12'd0,    1'b0, '0, '0, ST_DONE);
        add_row(MODE_ALLOC, 4'd0,  12'd0,    1'b0, '0, '0, ST_DONE);
        add_row(MODE_FREE,  4'd0,  12'd7,    1'b1, 12'd0,    9'd0, ST_IGNORED);
        add_row(MODE_FREE,  4'd4,  12'd4095, 1'b0, '0, '0, ST_DONE);
        add_row(MODE_FREE,  4'd7,  12'd1023, 1'b1, 12'd0,    9'd0, ST_IGNORED);
        add_row(MODE_ALLOC, 4'd7,  12'd0,    1'b0, '0, '0, ST_DONE);
        add_row(MODE_ALLOC, 4'd7,  12'd0,    1'b0, '0, '0, ST_DONE);
        add_row(MODE_ALLOC, 4'd7,  12'd0,    1'b0, '0, '0, ST_DONE);
        add_row(MODE_ALLOC, 4'd7,  12'd0,    1'b0, '0, '0, ST_DONE);
        add_row(MODE_FREE,  4'd1,  12'd15,   1'b1, 12'd0,    9'd0, ST_IGNORED);

        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        s_idle = 32;
        m_idle = 53;
        foreach (plan[k]) begin
            offer(plan[k].md, plan[k].cls, plan[k].off, plan[k].typed, plan[k].res);
        end
        run_random(700);

        s_idle = 53;
        m_idle = 32;
        run_random(700);

        // No idling; the receiver holds off once so the block backs up.
        s_idle = 0;
        m_idle = 0;
        hold_req = 1;
        run_random(600);
        i_s_tvalid <= 1'b0;

        while (grant_q.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (err_count == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule

### filelist.f
rtl/sfla_pkg.sv
rtl/slab_free_list_allocator.sv
tb/sv/slab_free_list_allocator_tb.sv
